// ===== sv/olt_pkg.sv =====
// Shared constants, codes and types for the ordered list table.
`default_nettype none
package olt_pkg;

   // Store size and the widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_READOUT = 2'd1,
      OP_REPLACE = 2'd2,
      OP_DELETE  = 2'd3
   } op_type;

   // Status codes returned with each result.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } state_type;

endpackage
`default_nettype wire

// ===== sv/olt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module olt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read in the same clock.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== sv/ordered_list_table_unit.sv =====
// Top level of the ordered list table: controller and entry store.
//
// Usage: an item is presented on req_op, req_value and req_new_value and is
// taken at a clock edge where start is high and busy is low. Results appear
// on rsp_data, rsp_status and rsp_last for exactly one cycle, marked by
// rsp_strobe; the receiver cannot hold them off. rsp_last marks the final
// result of each item.
// Append, and any operation on an empty list, gives its single result in
// the cycle after acceptance and leaves busy low, so such items can follow
// one another every cycle.
// Read-out, replace and delete walk the stored entries through the entry
// RAM, one read a cycle with a registered read: the item holds busy until
// its last result appears. Read-out gives one result a cycle. The walk
// rate is set by the single read port of the entry RAM; replace writes
// back one entry behind the read address and delete two entries behind.
// Reset clears the length to zero and returns the controller to idle; the
// RAM contents are not cleared, as entries at or above the length are never
// read.
`default_nettype none
module ordered_list_table_unit
   import olt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_op,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   output logic                          rsp_strobe,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   // Control registers.
   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_on_ff, rd_on_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               found_ff, found_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // Payload registers.
   op_type             op_ff, op_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [DATA_W-1:0]  nval_ff, nval_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [DATA_W-1:0]  rd_data;

   // Walk helpers.
   logic               accept;
   logic [LEN_W-1:0]   len_m1;
   logic               issue_last;
   logic               pend_last;
   logic               match;

   olt_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign len_m1     = len_ff - LEN_W'(1);
   assign issue_last = ({{(LEN_W-IDX_W){1'b0}}, rd_idx_ff} == len_m1);
   assign pend_last  = ({{(LEN_W-IDX_W){1'b0}}, pend_idx_ff} == len_m1);
   assign match      = (rd_data == value_ff);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         rd_on_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         rd_on_ff      <= rd_on_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload and index registers.
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      op_ff         <= op_in;
      value_ff      <= value_in;
      nval_ff       <= nval_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Next state, RAM accesses and results.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      rd_on_in      = rd_on_ff;
      pend_in       = 1'b0;
      pend_idx_in   = rd_idx_ff;
      found_in      = found_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      nval_in       = nval_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = len_ff[IDX_W-1:0];
      wr_data       = req_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_op);
               value_in  = req_value;
               nval_in   = req_new_value;
               rd_idx_in = '0;
               found_in  = 1'b0;
               if (op_type'(req_op) == OP_APPEND) begin
                  // Append stores at the tail unless the store is full.
                  rsp_strobe_in = 1'b1;
                  if (len_ff >= LEN_W'(CAPACITY)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end
               end else if (len_ff == '0) begin
                  // Every walking operation reports an empty list at once.
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rd_on_in = 1'b1;
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            // Issue one read a cycle until the last valid entry.
            if (rd_on_ff) begin
               pend_in   = 1'b1;
               rd_idx_in = rd_idx_ff + IDX_W'(1);
               rd_on_in  = !issue_last;
            end

            // Handle the entry that the RAM returned this cycle.
            if (pend_ff) begin
               case (op_ff)
                  OP_READOUT: begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = rd_data;
                     rsp_last_in   = pend_last;
                  end
                  OP_REPLACE: begin
                     if (match) begin
                        wr_en   = 1'b1;
                        wr_addr = pend_idx_ff;
                        wr_data = nval_ff;
                     end
                     rsp_strobe_in = pend_last;
                  end
                  OP_DELETE: begin
                     // After the first match each entry moves down one place.
                     if (found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = pend_idx_ff - IDX_W'(1);
                        wr_data = rd_data;
                     end else if (match) begin
                        found_in = 1'b1;
                     end
                     if (pend_last) begin
                        rsp_strobe_in = 1'b1;
                        if (found_ff || match) begin
                           len_in = len_m1;
                        end else begin
                           rsp_status_in = ST_NOTFOUND;
                        end
                     end
                  end
                  default: begin
                     rsp_strobe_in = pend_last;
                  end
               endcase
               if (pend_last) begin
                  state_in = S_IDLE;
                  rd_on_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ordered list table unit.
`default_nettype none
module testbench
   import olt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to let pass once nothing is expected any more.
   localparam int SETTLE_CYCLES = CAPACITY + 4;
   // Cycles with no item or result accepted before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 1000;
   // Random items in each idling phase.
   localparam int ITEMS_PER_PHASE = 28;

   typedef struct {
      op_type                     op;
      logic signed [DATA_W-1:0]   value;
      logic signed [DATA_W-1:0]   new_value;
   } list_cmd_type;

   typedef struct {
      logic signed [DATA_W-1:0]   data;
      status_type                 status;
      logic                       last;
   } list_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_op = OP_APPEND;
   logic signed [DATA_W-1:0]     req_value = '0;
   logic signed [DATA_W-1:0]     req_new_value = '0;
   logic                         rsp_strobe;
   logic signed [DATA_W-1:0]     rsp_data;
   logic [1:0]                   rsp_status;
   logic                         rsp_last;

   list_cmd_type                 cmd_q[$];
   list_rsp_type                 rsp_expect_q[$];
   logic signed [DATA_W-1:0]     list_model[$];
   int                           accepted_count = 0;
   int                           issued_count = 0;
   int                           queued_count = 0;
   int                           idle_pct = 0;
   int                           quiet_cycles = 0;
   int                           mismatch_count = 0;

   ordered_list_table_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one accepted item to the list model and queue the results it owes.
   function automatic void apply_list_op(list_cmd_type cmd);
      int hit;
      hit = -1;
      case (cmd.op)
         OP_APPEND: begin
            if (list_model.size() >= CAPACITY) begin
               rsp_expect_q.push_back('{'0, ST_FULL, 1'b1});
            end else begin
               list_model.push_back(cmd.value);
               rsp_expect_q.push_back('{'0, ST_OK, 1'b1});
            end
         end
         OP_READOUT: begin
            if (list_model.size() == 0) begin
               rsp_expect_q.push_back('{'0, ST_EMPTY, 1'b1});
            end else begin
               foreach (list_model[i])
                  rsp_expect_q.push_back('{list_model[i], ST_OK,
                                           i == list_model.size() - 1});
            end
         end
         OP_REPLACE: begin
            if (list_model.size() == 0) begin
               rsp_expect_q.push_back('{'0, ST_EMPTY, 1'b1});
            end else begin
               foreach (list_model[i])
                  if (list_model[i] == cmd.value) list_model[i] = cmd.new_value;
               rsp_expect_q.push_back('{'0, ST_OK, 1'b1});
            end
         end
         default: begin
            if (list_model.size() == 0) begin
               rsp_expect_q.push_back('{'0, ST_EMPTY, 1'b1});
            end else begin
               foreach (list_model[i])
                  if (hit < 0 && list_model[i] == cmd.value) hit = i;
               if (hit < 0) begin
                  rsp_expect_q.push_back('{'0, ST_NOTFOUND, 1'b1});
               end else begin
                  list_model.delete(hit);
                  rsp_expect_q.push_back('{'0, ST_OK, 1'b1});
               end
            end
         end
      endcase
   endfunction

   // Driver: a new item goes out at the falling edge once the previous one is taken.
   always @(negedge clock) begin
      if (!reset && (!start || accepted_count == issued_count)) begin
         if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_op        <= cmd_q[0].op;
            req_value     <= cmd_q[0].value;
            req_new_value <= cmd_q[0].new_value;
            void'(cmd_q.pop_front());
            issued_count = issued_count + 1;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each result against the oldest expectation, then record the
   // item taken at this edge.
   always @(posedge clock) begin
      list_rsp_type want;
      list_cmd_type got_cmd;
      if (!reset) begin
         if (rsp_strobe) begin
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: result with no expectation waiting: data %0d status %0d last %0b",
                        $realtime, rsp_data, rsp_status, rsp_last);
               mismatch_count++;
            end else begin
               want = rsp_expect_q.pop_front();
               if (rsp_data !== want.data) begin
                  $display("%0t: data expected %0d, got %0d", $realtime, want.data, rsp_data);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $realtime, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $realtime, want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            got_cmd.op        = op_type'(req_op);
            got_cmd.value     = req_value;
            got_cmd.new_value = req_new_value;
            apply_list_op(got_cmd);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // Count cycles in which neither an item nor a result is accepted.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no item or result accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Queue one item and wait until the block has taken it, so that the next
   // item can be built from the list contents as they now stand.
   task automatic send_item(input op_type op, input logic signed [DATA_W-1:0] value,
                            input logic signed [DATA_W-1:0] new_value);
      cmd_q.push_back('{op, value, new_value});
      queued_count++;
      wait (accepted_count == queued_count);
   endtask

   // Hold the sender back until every result owed has come.
   task automatic wait_until_drained();
      wait (rsp_expect_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly values already stored or a few corner values, so that searches hit.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 45 && list_model.size() > 0)
         return list_model[$urandom_range(list_model.size() - 1)];
      if (r < 75) begin
         case ($urandom_range(6))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            4: return 32'sd1;
            5: return 32'sd2;
            default: return 32'sd3;
         endcase
      end
      return $urandom;
   endfunction

   // Random items in stretches that favour filling, mixing or draining the list.
   task automatic send_random_items(input int count);
      int append_pct;
      int r;
      op_type op;
      append_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 12 == 0) begin
            case ($urandom_range(2))
               0: append_pct = 85;
               1: append_pct = 45;
               default: append_pct = 10;
            endcase
         end
         // Now and then let the block run dry before the next item.
         if ($urandom_range(19) == 0) wait_until_drained();
         r = $urandom_range(99);
         if (r < append_pct) op = OP_APPEND;
         else begin
            r = $urandom_range(99);
            if (r < 20) op = OP_READOUT;
            else if (r < 50) op = OP_REPLACE;
            else op = OP_DELETE;
         end
         send_item(op, pick_value(), pick_value());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Operations on the empty list.
      send_item(OP_READOUT, 32'sd0, 32'sd0);
      send_item(OP_REPLACE, 32'sd0, -32'sd1);
      send_item(OP_DELETE, 32'sh7fff_ffff, 32'sh8000_0000);

      // Fill the store with extremes and repeated values, then one more append.
      send_item(OP_APPEND, 32'sh8000_0000, 32'sd0);
      send_item(OP_APPEND, 32'sh7fff_ffff, 32'sd0);
      send_item(OP_APPEND, -32'sd1, 32'sd0);
      send_item(OP_APPEND, 32'sd0, 32'sd0);
      for (int i = 0; i < 12; i++)
         send_item(OP_APPEND, (i % 3 == 0) ? 32'sd5 : 32'sd100 + i, 32'sd0);
      send_item(OP_APPEND, 32'sd23, 32'sd0);

      // Full read-out, replace of repeated entries, absent and present deletes.
      send_item(OP_READOUT, 32'sd0, 32'sd0);
      send_item(OP_REPLACE, 32'sd5, 32'sh8000_0000);
      send_item(OP_DELETE, 32'sd1234, 32'sd0);
      send_item(OP_DELETE, 32'sh8000_0000, 32'sd0);
      send_item(OP_READOUT, -32'sd1, 32'sh7fff_ffff);
      wait_until_drained();

      // Random phases: no idling, sender idle half the time, then about a third.
      idle_pct = 0;
      send_random_items(ITEMS_PER_PHASE);
      wait_until_drained();
      idle_pct = 50;
      send_random_items(ITEMS_PER_PHASE);
      wait_until_drained();
      idle_pct = 31;
      send_random_items(ITEMS_PER_PHASE);
      wait_until_drained();

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/olt_pkg.sv
sv/olt_ram.sv
sv/ordered_list_table_unit.sv
tb/testbench.sv
